>>> rtl/maft_pkg.sv
// Shared types and constants for the MAC address filter table.
// No dependencies; used by maft_key_ram, maft_ctrl and the top level.
`default_nettype none

package maft_pkg;

  localparam int MAC_W   = 48;
  localparam int VLAN_W  = 12;
  localparam int KEY_W   = MAC_W + VLAN_W;
  localparam int OP_W    = 2;
  localparam int USED_W  = 9;

  // Operation codes; the unused code behaves as a lookup.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // One table slot: valid mark plus {mac, vlan}.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Result of one request, handed from the controller to the output register.
  typedef struct packed {
    logic              found;
    logic              refused;
    logic [USED_W-1:0] entries_used;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/mac_address_filter_table_unit.sv
// Top level of the MAC address filter table: config register, output register.
// Depends on maft_pkg, maft_key_ram and maft_ctrl.
`default_nettype none

// Exact-match set of up to ENTRIES keys, each a 48-bit MAC address, or MAC plus
// 12-bit VLAN id when match_vlan (register 0, byte address 0) is set. Every
// request is a lookup, add or delete and yields one result: found (key present
// before the request), refused (add to a full table) and entries_used (stored
// keys after the request, low 9 bits). Keys live in a single-port-read RAM that
// is scanned one slot per cycle, and a request holds the block through the
// accept cycle, one read per slot until the lowest matching slot is seen (or
// all ENTRIES slots are read), the read latency, the write-back and the hand-over
// of the result to the output register, which waits while that register is
// full and stalled. A request whose key is present stops the scan early.
// After reset the RAM valid marks are swept clear, one slot per cycle, and
// in_stall stays high meanwhile; configuration writes are taken at any time.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits.
module mac_address_filter_table_unit #(
  parameter int ENTRIES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [maft_pkg::OP_W-1:0]   operation,
  input  wire logic [maft_pkg::MAC_W-1:0]  mac,
  input  wire logic [maft_pkg::VLAN_W-1:0] vlan,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             found,
  output logic                             refused,
  output logic [maft_pkg::USED_W-1:0]      entries_used,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic              match_vlan;
  logic              cfg_wr;
  logic              sel_reg0;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  maft_pkg::entry_t  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  maft_pkg::entry_t  mem_rdata;

  logic              res_valid;
  maft_pkg::result_t res;
  logic              res_take;

  // Config: one register at word 0; byte-offset bits are ignored.
  assign pready   = 1'b1;
  assign sel_reg0 = (paddr[2] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = sel_reg0 ? {31'd0, match_vlan} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_vlan <= 1'b0;
    end else if (cfg_wr && sel_reg0) begin
      match_vlan <= pwdata[0];
    end
  end

  maft_key_ram #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  maft_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .mac        (mac),
    .vlan       (vlan),
    .match_vlan (match_vlan),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      found        <= res.found;
      refused      <= res.refused;
      entries_used <= res.entries_used;
    end
  end

endmodule

`default_nettype wire

>>> rtl/maft_key_ram.sv
// Table storage: one write port, one read port, registered read data.
// Depends on maft_pkg for the slot layout.
`default_nettype none

module maft_key_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire maft_pkg::entry_t  wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output maft_pkg::entry_t       rdata
);

  maft_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/maft_ctrl.sv
// Request sequencer: clears the table after reset, scans it per request,
// then writes back an add or delete. Depends on maft_pkg.
`default_nettype none

module maft_ctrl #(
  parameter int ENTRIES = 256,
  parameter int AW      = 8,
  parameter int CW      = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [maft_pkg::OP_W-1:0]   operation,
  input  wire logic [maft_pkg::MAC_W-1:0]  mac,
  input  wire logic [maft_pkg::VLAN_W-1:0] vlan,
  input  wire logic                        match_vlan,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output maft_pkg::entry_t                 mem_wdata,
  output logic                             mem_re,
  output logic [AW-1:0]                    mem_raddr,
  input  wire maft_pkg::entry_t            mem_rdata,
  output logic                             res_valid,
  output maft_pkg::result_t                res,
  input  wire logic                        res_take
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [AW:0] ENT_C  = (AW+1)'(ENTRIES);
  localparam logic [AW:0] LAST_C = (AW+1)'(ENTRIES - 1);

  logic [1:0]                      state;
  logic [AW:0]                     iss;
  logic                            pend;
  logic [AW-1:0]                   cmp_addr;
  logic                            hit;
  logic [AW-1:0]                   hit_addr;
  logic                            free_ok;
  logic [AW-1:0]                   free_addr;
  logic [CW-1:0]                   count;
  logic [maft_pkg::OP_W-1:0]       op_q;
  logic [maft_pkg::KEY_W-1:0]      key_q;
  logic                            mode_q;

  logic                            accept;
  logic                            issue;
  logic                            scan_end;
  logic                            clearing;
  logic                            match;
  logic                            do_add;
  logic                            do_del;
  logic [CW+maft_pkg::USED_W-1:0]  count_ext;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign clearing = (state == S_CLEAR);
  assign issue    = (state == S_SCAN) && !hit && (iss != ENT_C);
  assign scan_end = (state == S_SCAN) && !pend && (hit || (iss == ENT_C));

  // MAC always compared; VLAN only in keyed mode.
  assign match = mem_rdata.valid &&
                 (mem_rdata.key[maft_pkg::KEY_W-1:maft_pkg::VLAN_W] ==
                  key_q[maft_pkg::KEY_W-1:maft_pkg::VLAN_W]) &&
                 (!mode_q ||
                  (mem_rdata.key[maft_pkg::VLAN_W-1:0] == key_q[maft_pkg::VLAN_W-1:0]));

  assign do_add = scan_end && (op_q == maft_pkg::OP_ADD) && !hit && free_ok;
  assign do_del = scan_end && (op_q == maft_pkg::OP_DELETE) && hit;

  assign mem_re    = issue;
  assign mem_raddr = iss[AW-1:0];
  assign mem_we    = clearing || do_add || do_del;

  always_comb begin
    if (clearing) begin
      mem_waddr = iss[AW-1:0];
    end else if (do_add) begin
      mem_waddr = free_addr;
    end else begin
      mem_waddr = hit_addr;
    end
    mem_wdata.valid = do_add;
    mem_wdata.key   = key_q;
  end

  assign count_ext = {{maft_pkg::USED_W{1'b0}}, count};

  assign res_valid        = (state == S_DONE);
  assign res.found        = hit;
  assign res.refused      = (op_q == maft_pkg::OP_ADD) && !hit && !free_ok;
  assign res.entries_used = count_ext[maft_pkg::USED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      iss     <= '0;
      pend    <= 1'b0;
      hit     <= 1'b0;
      free_ok <= 1'b0;
      count   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          iss <= iss + 1'b1;
          if (iss == LAST_C) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            iss     <= '0;
            pend    <= 1'b0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            iss <= iss + 1'b1;
          end
          if (pend && !hit) begin
            if (match) begin
              hit <= 1'b1;
            end else if (!mem_rdata.valid && !free_ok) begin
              free_ok <= 1'b1;
            end
          end
          if (scan_end) begin
            if (do_add) begin
              count <= count + 1'b1;
            end else if (do_del && (count != '0)) begin
              count <= count - 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Payload: request fields and slot addresses.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      mode_q <= match_vlan;
      key_q  <= {mac, (match_vlan ? vlan : {maft_pkg::VLAN_W{1'b0}})};
    end
    if (issue) begin
      cmp_addr <= iss[AW-1:0];
    end
    if ((state == S_SCAN) && pend && !hit) begin
      if (match) begin
        hit_addr <= cmp_addr;
      end else if (!mem_rdata.valid && !free_ok) begin
        free_addr <= cmp_addr;
      end
    end
  end

endmodule

`default_nettype wire
